/* src/mbrtu_pkg.sv */
// Package for the Modbus RTU request parser: result type, function codes and CRC step.
package mbrtu_pkg;

  localparam logic [7:0] FC_READ_FIRST   = 8'd1;
  localparam logic [7:0] FC_READ_LAST    = 8'd4;
  localparam logic [7:0] FC_WRITE_COIL   = 8'd5;
  localparam logic [7:0] FC_WRITE_REG    = 8'd6;
  localparam logic [7:0] FC_WRITE_COILS  = 8'd15;
  localparam logic [7:0] FC_WRITE_REGS   = 8'd16;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Byte positions of the request header.
  localparam logic [7:0] POS_ID       = 8'd0;
  localparam logic [7:0] POS_FUNC     = 8'd1;
  localparam logic [7:0] POS_ADDR_HI  = 8'd2;
  localparam logic [7:0] POS_ADDR_LO  = 8'd3;
  localparam logic [7:0] POS_QTY_HI   = 8'd4;
  localparam logic [7:0] POS_QTY_LO   = 8'd5;
  localparam logic [7:0] POS_COUNT    = 8'd6;
  localparam logic [7:0] POS_PAYLOAD  = 8'd7;
  localparam logic [7:0] POS_MAX      = 8'hFF;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  slave_id;
    logic [7:0]  function_code;
    logic [15:0] start_address;
    logic [15:0] quantity;
    logic [15:0] value;
    logic [7:0]  value_index;
    logic        crc_ok;
  } result_t;

  // One byte of the reflected Modbus CRC-16, bit by bit.
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* src/modbus_rtu_request_parser_top.sv */
// Top level of the Modbus RTU request parser with running CRC-16.
//
//   channel | direction | handshake            | payload
//   in      | to block  | in_valid / in_stall  | data_byte, frame_end
//   out     | from block| out_valid / out_stall| result_kind ... crc_ok
//
// Each byte is decoded in the cycle it is transferred; its result, if any,
// is registered in the output register, or in the skid register while the
// output is stalled. One byte per cycle is sustained while in_stall is low,
// and in_stall rises only while that skid register holds a second result.
// Synchronous reset returns the CRC to 0xFFFF and clears all frame state.
module modbus_rtu_request_parser_top #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        frame_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        result_kind,
  output logic [7:0]  slave_id,
  output logic [7:0]  function_code,
  output logic [15:0] start_address,
  output logic [15:0] quantity,
  output logic [15:0] value,
  output logic [7:0]  value_index,
  output logic        crc_ok
);

  localparam logic [8:0] FRAME_LIMIT = 9'(MAX_FRAME_BYTES);

  logic [15:0] crc_register, crc_register_next;
  logic [7:0]  byte_position, byte_position_next;
  logic [7:0]  held_id, held_id_next;
  logic [7:0]  held_function, held_function_next;
  logic [15:0] held_address, held_address_next;
  logic [15:0] held_quantity, held_quantity_next;
  logic [7:0]  coil_byte_count, coil_byte_count_next;
  logic [7:0]  high_byte_hold, high_byte_hold_next;
  logic [7:0]  values_emitted, values_emitted_next;

  mbrtu_pkg::result_t out_data, skid_data, result;
  logic skid_valid;

  logic accept, produce, out_free;
  logic known, is_single_now, is_multi_now, single_next, have_item;
  logic [15:0] item_val;

  assign accept   = in_valid && !in_stall;
  assign in_stall = skid_valid;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    is_single_now = (held_function == mbrtu_pkg::FC_WRITE_COIL) ||
                    (held_function == mbrtu_pkg::FC_WRITE_REG);
    is_multi_now  = (held_function == mbrtu_pkg::FC_WRITE_COILS) ||
                    (held_function == mbrtu_pkg::FC_WRITE_REGS);
    known = ((held_function >= mbrtu_pkg::FC_READ_FIRST) &&
             (held_function <= mbrtu_pkg::FC_READ_LAST)) || is_single_now || is_multi_now;

    crc_register_next    = mbrtu_pkg::crc_update(crc_register, data_byte);
    held_id_next         = held_id;
    held_function_next   = held_function;
    held_address_next    = held_address;
    held_quantity_next   = held_quantity;
    coil_byte_count_next = coil_byte_count;
    high_byte_hold_next  = high_byte_hold;
    values_emitted_next  = values_emitted;
    have_item            = 1'b0;
    item_val             = 16'h0000;

    if (byte_position == mbrtu_pkg::POS_ID) begin
      held_id_next = data_byte;
    end else if (byte_position == mbrtu_pkg::POS_FUNC) begin
      held_function_next = data_byte;
    end else if (known && (byte_position == mbrtu_pkg::POS_ADDR_HI ||
                           byte_position == mbrtu_pkg::POS_QTY_HI)) begin
      high_byte_hold_next = data_byte;
    end else if (known && byte_position == mbrtu_pkg::POS_ADDR_LO) begin
      held_address_next = {high_byte_hold, data_byte};
    end else if (known && byte_position == mbrtu_pkg::POS_QTY_LO) begin
      held_quantity_next = {high_byte_hold, data_byte};
    end else if (is_multi_now && byte_position == mbrtu_pkg::POS_COUNT) begin
      coil_byte_count_next = data_byte;
    end else if (byte_position >= mbrtu_pkg::POS_PAYLOAD && byte_position != mbrtu_pkg::POS_MAX
                 && {1'b0, byte_position} < FRAME_LIMIT) begin
      if (held_function == mbrtu_pkg::FC_WRITE_COILS) begin
        if (values_emitted < coil_byte_count) begin
          have_item = 1'b1;
          item_val  = {8'h00, data_byte};
        end
      end else if (held_function == mbrtu_pkg::FC_WRITE_REGS) begin
        if ({8'h00, values_emitted} < held_quantity) begin
          // Payload starts at an odd position, so odd positions carry high bytes.
          if (byte_position[0]) begin
            high_byte_hold_next = data_byte;
          end else begin
            have_item = 1'b1;
            item_val  = {high_byte_hold, data_byte};
          end
        end
      end
    end

    byte_position_next = (byte_position == mbrtu_pkg::POS_MAX) ? byte_position
                                                               : byte_position + 8'd1;

    single_next = (held_function_next == mbrtu_pkg::FC_WRITE_COIL) ||
                  (held_function_next == mbrtu_pkg::FC_WRITE_REG);

    result.slave_id      = held_id_next;
    result.function_code = held_function_next;
    result.start_address = held_address_next;
    result.quantity      = single_next ? 16'd1 : held_quantity_next;
    result.value_index   = values_emitted;
    if (frame_end) begin
      result.result_kind = mbrtu_pkg::KIND_SUMMARY;
      result.value       = single_next ? held_quantity_next : 16'h0000;
      result.crc_ok      = (crc_register_next == 16'h0000);
    end else begin
      result.result_kind = mbrtu_pkg::KIND_DATA;
      result.value       = item_val;
      result.crc_ok      = 1'b0;
    end

    if (have_item && !frame_end && values_emitted != 8'hFF) begin
      values_emitted_next = values_emitted + 8'd1;
    end

    produce = accept && (frame_end || have_item);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_register    <= mbrtu_pkg::CRC_INIT;
      byte_position   <= 8'd0;
      held_id         <= 8'd0;
      held_function   <= 8'd0;
      held_address    <= 16'd0;
      held_quantity   <= 16'd0;
      coil_byte_count <= 8'd0;
      high_byte_hold  <= 8'd0;
      values_emitted  <= 8'd0;
    end else if (accept) begin
      if (frame_end) begin
        // The parser re-arms for the next frame after the summary.
        crc_register    <= mbrtu_pkg::CRC_INIT;
        byte_position   <= 8'd0;
        held_id         <= 8'd0;
        held_function   <= 8'd0;
        held_address    <= 16'd0;
        held_quantity   <= 16'd0;
        coil_byte_count <= 8'd0;
        high_byte_hold  <= 8'd0;
        values_emitted  <= 8'd0;
      end else begin
        crc_register    <= crc_register_next;
        byte_position   <= byte_position_next;
        held_id         <= held_id_next;
        held_function   <= held_function_next;
        held_address    <= held_address_next;
        held_quantity   <= held_quantity_next;
        coil_byte_count <= coil_byte_count_next;
        high_byte_hold  <= high_byte_hold_next;
        values_emitted  <= values_emitted_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= produce;
      end
    end else if (produce) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (produce) begin
        out_data <= result;
      end
    end else if (produce) begin
      skid_data <= result;
    end
  end

  assign result_kind   = out_data.result_kind;
  assign slave_id      = out_data.slave_id;
  assign function_code = out_data.function_code;
  assign start_address = out_data.start_address;
  assign quantity      = out_data.quantity;
  assign value         = out_data.value;
  assign value_index   = out_data.value_index;
  assign crc_ok        = out_data.crc_ok;

endmodule

/* tb/modbus_rtu_request_parser_top_test.sv */
// Testbench for the Modbus RTU request parser: directed and random frames with a scoreboard.
module modbus_rtu_request_parser_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_LIMIT = 256;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        frame_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        result_kind;
  logic [7:0]  slave_id;
  logic [7:0]  function_code;
  logic [15:0] start_address;
  logic [15:0] quantity;
  logic [15:0] value;
  logic [7:0]  value_index;
  logic        crc_ok;

  // Parser state as predicted by the testbench.
  logic [15:0] crc_acc;
  logic [7:0]  byte_pos;
  logic [7:0]  frame_id;
  logic [7:0]  frame_func;
  logic [15:0] frame_addr;
  logic [15:0] frame_qty;
  logic [7:0]  coil_count;
  logic [7:0]  hi_byte;
  logic [7:0]  items_out;

  mbrtu_pkg::result_t pending_results[$];
  logic [7:0]  frame_bytes[$];
  int          error_count = 0;
  int          bytes_sent = 0;
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;

  modbus_rtu_request_parser_top #(
    .MAX_FRAME_BYTES(FRAME_LIMIT)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .frame_end     (frame_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_kind   (result_kind),
    .slave_id      (slave_id),
    .function_code (function_code),
    .start_address (start_address),
    .quantity      (quantity),
    .value         (value),
    .value_index   (value_index),
    .crc_ok        (crc_ok)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [15:0] crc16_modbus(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    logic        lsb;
    c = acc ^ {8'h00, b};
    repeat (8) begin
      lsb = c[0];
      c = {1'b0, c[15:1]};
      if (lsb) begin
        c = c ^ mbrtu_pkg::CRC_POLY;
      end
    end
    return c;
  endfunction

  task automatic clear_parser_state();
    crc_acc    = mbrtu_pkg::CRC_INIT;
    byte_pos   = mbrtu_pkg::POS_ID;
    frame_id   = 8'h00;
    frame_func = 8'h00;
    frame_addr = 16'h0000;
    frame_qty  = 16'h0000;
    coil_count = 8'h00;
    hi_byte    = 8'h00;
    items_out  = 8'h00;
  endtask

  function automatic mbrtu_pkg::result_t make_result(input logic kind, input logic [15:0] val,
                                                     input logic [7:0] idx, input logic ok);
    mbrtu_pkg::result_t r;
    logic    single;
    single          = (frame_func == mbrtu_pkg::FC_WRITE_COIL) ||
                      (frame_func == mbrtu_pkg::FC_WRITE_REG);
    r.result_kind   = kind;
    r.slave_id      = frame_id;
    r.function_code = frame_func;
    r.start_address = frame_addr;
    r.quantity      = single ? 16'd1 : frame_qty;
    r.value         = val;
    r.value_index   = idx;
    r.crc_ok        = ok;
    return r;
  endfunction

  // Advances the predicted parser by one byte and queues the result it causes.
  task automatic parse_request_byte(input logic [7:0] b, input logic last);
    logic [7:0]  p;
    logic [7:0]  f;
    logic        known;
    logic        multi;
    logic        have_item;
    logic [15:0] item_val;
    logic [15:0] single_val;
    p         = byte_pos;
    f         = frame_func;
    multi     = (f == mbrtu_pkg::FC_WRITE_COILS) || (f == mbrtu_pkg::FC_WRITE_REGS);
    known     = (f >= mbrtu_pkg::FC_READ_FIRST && f <= mbrtu_pkg::FC_READ_LAST) ||
                f == mbrtu_pkg::FC_WRITE_COIL || f == mbrtu_pkg::FC_WRITE_REG || multi;
    have_item = 1'b0;
    item_val  = 16'h0000;
    crc_acc   = crc16_modbus(crc_acc, b);

    if (p == mbrtu_pkg::POS_ID) begin
      frame_id = b;
    end else if (p == mbrtu_pkg::POS_FUNC) begin
      frame_func = b;
    end else if (known && (p == mbrtu_pkg::POS_ADDR_HI || p == mbrtu_pkg::POS_QTY_HI)) begin
      hi_byte = b;
    end else if (known && p == mbrtu_pkg::POS_ADDR_LO) begin
      frame_addr = {hi_byte, b};
    end else if (known && p == mbrtu_pkg::POS_QTY_LO) begin
      frame_qty = {hi_byte, b};
    end else if (multi && p == mbrtu_pkg::POS_COUNT) begin
      coil_count = b;
    end else if (p >= mbrtu_pkg::POS_PAYLOAD && p < mbrtu_pkg::POS_MAX &&
                 int'(p) < FRAME_LIMIT) begin
      if (f == mbrtu_pkg::FC_WRITE_COILS) begin
        if (items_out < coil_count) begin
          have_item = 1'b1;
          item_val  = {8'h00, b};
        end
      end else if (f == mbrtu_pkg::FC_WRITE_REGS) begin
        // Register words start at an odd position: high byte first, then low.
        if ({8'h00, items_out} < frame_qty) begin
          if (p[0]) begin
            hi_byte = b;
          end else begin
            have_item = 1'b1;
            item_val  = {hi_byte, b};
          end
        end
      end
    end

    if (byte_pos != mbrtu_pkg::POS_MAX) begin
      byte_pos = byte_pos + 8'd1;
    end

    if (last) begin
      single_val = (frame_func == mbrtu_pkg::FC_WRITE_COIL ||
                    frame_func == mbrtu_pkg::FC_WRITE_REG) ? frame_qty : 16'h0000;
      pending_results.push_back(make_result(mbrtu_pkg::KIND_SUMMARY, single_val, items_out,
                                            crc_acc == 16'h0000));
      clear_parser_state();
    end else if (have_item) begin
      pending_results.push_back(make_result(mbrtu_pkg::KIND_DATA, item_val, items_out, 1'b0));
      if (items_out != 8'hFF) begin
        items_out = items_out + 8'd1;
      end
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    data_byte = b;
    frame_end = last;
    do @(posedge clk); while (in_stall);
    parse_request_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic start_frame(input logic [7:0] id, input logic [7:0] func);
    frame_bytes.delete();
    frame_bytes.push_back(id);
    frame_bytes.push_back(func);
  endtask

  task automatic push_word(input logic [15:0] w);
    frame_bytes.push_back(w[15:8]);
    frame_bytes.push_back(w[7:0]);
  endtask

  // keep_len of zero sends the whole frame; otherwise the frame is cut to at most keep_len bytes.
  task automatic send_frame(input bit add_crc, input bit corrupt, input int keep_len);
    logic [15:0] crc;
    int          idx;
    int          bit_sel;
    if (add_crc) begin
      crc = mbrtu_pkg::CRC_INIT;
      foreach (frame_bytes[i]) begin
        crc = crc16_modbus(crc, frame_bytes[i]);
      end
      frame_bytes.push_back(crc[7:0]);
      frame_bytes.push_back(crc[15:8]);
    end
    if (corrupt) begin
      idx     = $urandom_range(frame_bytes.size() - 1);
      bit_sel = $urandom_range(7);
      frame_bytes[idx][bit_sel] = ~frame_bytes[idx][bit_sel];
    end
    if (keep_len > 0) begin
      while (frame_bytes.size() > keep_len) begin
        void'(frame_bytes.pop_back());
      end
    end
    foreach (frame_bytes[i]) begin
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    end
  endtask

  task automatic build_random_request();
    int          pick;
    int          n;
    logic [7:0]  func;
    logic [15:0] qty;
    pick = $urandom_range(99);
    if (pick < 15) begin
      start_frame(8'($urandom),
                  8'($urandom_range(mbrtu_pkg::FC_READ_LAST, mbrtu_pkg::FC_READ_FIRST)));
      push_word(16'($urandom));
      push_word(16'($urandom));
    end else if (pick < 30) begin
      start_frame(8'($urandom),
                  $urandom_range(1) ? mbrtu_pkg::FC_WRITE_COIL : mbrtu_pkg::FC_WRITE_REG);
      push_word(16'($urandom));
      push_word(16'($urandom));
    end else if (pick < 55) begin
      start_frame(8'($urandom), mbrtu_pkg::FC_WRITE_COILS);
      push_word(16'($urandom));
      push_word(16'($urandom));
      n = $urandom_range(6);
      frame_bytes.push_back($urandom_range(9) == 0 ? 8'($urandom_range(255)) : 8'(n));
      // Sometimes more or fewer data bytes than the byte count announces.
      if ($urandom_range(4) == 0) begin
        n = $urandom_range(8);
      end
      repeat (n) frame_bytes.push_back(8'($urandom));
    end else if (pick < 85) begin
      start_frame(8'($urandom), mbrtu_pkg::FC_WRITE_REGS);
      push_word(16'($urandom));
      n   = $urandom_range(5);
      qty = ($urandom_range(9) == 0) ? 16'($urandom) : 16'(n);
      push_word(qty);
      frame_bytes.push_back($urandom_range(9) == 0 ? 8'($urandom) : 8'(2 * n));
      if ($urandom_range(4) == 0) begin
        n = $urandom_range(6);
      end
      repeat (2 * n) frame_bytes.push_back(8'($urandom));
    end else begin
      do func = 8'($urandom);
      while ((func >= mbrtu_pkg::FC_READ_FIRST && func <= mbrtu_pkg::FC_READ_LAST) ||
             func == mbrtu_pkg::FC_WRITE_COIL || func == mbrtu_pkg::FC_WRITE_REG ||
             func == mbrtu_pkg::FC_WRITE_COILS || func == mbrtu_pkg::FC_WRITE_REGS);
      start_frame(8'($urandom), func);
      repeat ($urandom_range(8)) frame_bytes.push_back(8'($urandom));
    end
  endtask

  task automatic test_directed_frames();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    // Read with extreme id, address and quantity.
    start_frame(8'hFF, mbrtu_pkg::FC_READ_FIRST);
    push_word(16'hFFFF);
    push_word(16'h0000);
    send_frame(1'b1, 1'b0, 0);
    // Single register write with a damaged transfer.
    start_frame(8'h00, mbrtu_pkg::FC_WRITE_REG);
    push_word(16'h0000);
    push_word(16'hFFFF);
    send_frame(1'b1, 1'b1, 0);
    // One register word, then the CRC bytes as excess payload.
    start_frame(8'h55, mbrtu_pkg::FC_WRITE_REGS);
    push_word(16'h1234);
    push_word(16'h0001);
    frame_bytes.push_back(8'h02);
    push_word(16'hA5C3);
    send_frame(1'b1, 1'b0, 0);
    // Frame that ends on its first byte.
    start_frame(8'hAA, 8'h00);
    send_frame(1'b0, 1'b0, 1);
    // Unknown function code.
    start_frame(8'h01, 8'h00);
    frame_bytes.push_back(8'hFF);
    send_frame(1'b0, 1'b0, 0);
  endtask

  task automatic test_random_requests(input int idle_pct, input int stall_pct,
                                      input int byte_budget);
    int start_count;
    int pick;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    start_count        = bytes_sent;
    while (bytes_sent - start_count < byte_budget) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        // Line noise: random bytes closed by a frame end.
        start_frame(8'($urandom), 8'($urandom));
        repeat ($urandom_range(10)) frame_bytes.push_back(8'($urandom));
        send_frame(1'b0, 1'b0, 0);
      end else begin
        build_random_request();
        if (pick < 22) begin
          send_frame(1'b1, 1'b1, 0);
        end else if (pick < 30) begin
          send_frame(1'b1, 1'b0, $urandom_range(frame_bytes.size() + 1, 1));
        end else begin
          send_frame(1'b1, 1'b0, 0);
        end
      end
    end
  endtask

  // Register frame longer than the position counter can count.
  task automatic test_long_frame();
    sender_idle_pct    = 20;
    receiver_stall_pct = 20;
    start_frame(8'($urandom), mbrtu_pkg::FC_WRITE_REGS);
    push_word(16'($urandom));
    push_word(16'h00FF);
    frame_bytes.push_back(8'hFE);
    while (frame_bytes.size() < 262) begin
      frame_bytes.push_back(8'($urandom));
    end
    send_frame(1'b1, 1'b0, 0);
  endtask

  task automatic check_field(input string name, input logic [15:0] expected,
                             input logic [15:0] actual);
    if (actual !== expected) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, expected, actual);
      error_count++;
    end
  endtask

  task automatic check_result();
    mbrtu_pkg::result_t exp;
    if (pending_results.size() == 0) begin
      $error("unexpected result: kind %0d id 0x%0h function 0x%0h",
             result_kind, slave_id, function_code);
      error_count++;
    end else begin
      exp = pending_results.pop_front();
      check_field("result_kind", 16'(exp.result_kind), 16'(result_kind));
      check_field("slave_id", 16'(exp.slave_id), 16'(slave_id));
      check_field("function_code", 16'(exp.function_code), 16'(function_code));
      check_field("start_address", exp.start_address, start_address);
      check_field("quantity", exp.quantity, quantity);
      check_field("value", exp.value, value);
      check_field("value_index", 16'(exp.value_index), 16'(value_index));
      check_field("crc_ok", 16'(exp.crc_ok), 16'(crc_ok));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      check_result();
    end
  end

  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < receiver_stall_pct);
  end

  initial begin
    clear_parser_state();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_frames();
    test_random_requests(0, 0, 50);
    test_random_requests(73, 0, 50);
    test_random_requests(0, 73, 50);
    test_random_requests(20, 20, 50);
    test_long_frame();
    in_valid = 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* filelist.f */
src/mbrtu_pkg.sv
src/modbus_rtu_request_parser_top.sv
tb/modbus_rtu_request_parser_top_test.sv
